// File: hw/rtl/rrb3_pkg.sv
// shared constants for the ranrot b3 random generator
// ring geometry, tap offsets, rotation amounts, seed-fill constants and warm-up length
// no dependencies
package rrb3_pkg;

    localparam int WORD_W          = 64;
    localparam int RING_LEN        = 27;
    localparam int IDX_W           = $clog2(RING_LEN);
    localparam int TAP_TWO_START   = 10;
    localparam int TAP_THREE_START = 21;
    localparam int ROT_A           = 5;
    localparam int ROT_B           = 3;
    localparam int ROT_C           = 53;
    localparam int SEED_ROT        = 5;
    localparam int SEED_ADD        = 97;
    localparam int WARMUP_DRAWS    = 50000;
    localparam int WARM_W          = (WARMUP_DRAWS > 1) ? $clog2(WARMUP_DRAWS) : 1;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]  t_idx;

endpackage

// File: hw/rtl/ranrot_b3_random_generator.sv
// top level of the 64-bit ranrot b3 random generator
// keeps the 27-word ring in one rrb3_ram instance; uses rrb3_pkg
//
// A beat with i_func set draws one 64-bit word and returns it on the output
// channel; a beat with i_func clear reseeds from i_seed and returns nothing.
// The ring sits in a ram with one read port, so a draw reads its three taps
// one per cycle in S_RDA, S_RDB and S_RDC and writes the sum back in S_SUM,
// after the beat is accepted in S_IDLE. A reseed writes the 27 ring words one
// per cycle and then runs 50000 discarded draws; o_ready stays low throughout.
// A finished result waits in an output register; the next beat is taken while
// it waits, and that draw holds in S_SUM until the waiting word is taken.
// After reset the ring reads as zero through per-word valid bits, so there is
// no clearing pass.
module ranrot_b3_random_generator (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_func,
    input  logic [rrb3_pkg::WORD_W-1:0] i_seed,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [rrb3_pkg::WORD_W-1:0] o_value
);

    import rrb3_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_RDA  = 3'd2;
    localparam logic [2:0] S_RDB  = 3'd3;
    localparam logic [2:0] S_RDC  = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;

    localparam t_idx LAST_IDX = t_idx'(RING_LEN - 1);

    function automatic t_word rotl(input t_word x, input int r);
        return (x << r) | (x >> (WORD_W - r));
    endfunction

    function automatic t_idx step_down(input t_idx i);
        return (i == '0) ? LAST_IDX : t_idx'(i - 1'b1);
    endfunction

    logic [2:0]        r_state, n_state;
    t_idx              r_cnt, n_cnt;
    t_word             r_fill_word, n_fill_word;
    t_idx              r_idx_a, n_idx_a;
    t_idx              r_idx_b, n_idx_b;
    t_idx              r_idx_c, n_idx_c;
    logic              r_warm, n_warm;
    logic [WARM_W-1:0] r_warm_cnt, n_warm_cnt;
    t_word             r_word_a, n_word_a;
    t_word             r_word_b, n_word_b;
    logic              r_rd_vld;
    logic [RING_LEN-1:0] r_vld;
    logic              r_out_vld, n_out_vld;
    t_word             r_out_value, n_out_value;

    logic  ram_we;
    t_idx  ram_waddr;
    t_word ram_wdata;
    t_idx  ram_raddr;
    t_word ram_rdata;
    t_word word_c;
    t_word sum;
    logic  proceed;

    rrb3_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RING_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // never-written words read as zero
    assign word_c  = r_rd_vld ? ram_rdata : '0;
    assign sum     = rotl(r_word_a, ROT_A) + rotl(r_word_b, ROT_B) + rotl(word_c, ROT_C);
    assign proceed = r_warm || !r_out_vld || i_ready;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_vld;
    assign o_value = r_out_value;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx_a;
        ram_wdata = sum;
        ram_raddr = r_idx_a;
        unique case (r_state)
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = r_fill_word;
            end
            S_RDB: ram_raddr = r_idx_b;
            S_RDC: ram_raddr = r_idx_c;
            S_SUM: begin
                ram_we    = proceed;
                ram_raddr = r_idx_c;
            end
            default: ram_raddr = r_idx_a;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_fill_word = r_fill_word;
        n_idx_a     = r_idx_a;
        n_idx_b     = r_idx_b;
        n_idx_c     = r_idx_c;
        n_warm      = r_warm;
        n_warm_cnt  = r_warm_cnt;
        n_word_a    = r_word_a;
        n_word_b    = r_word_b;
        n_out_vld   = r_out_vld && !i_ready;
        n_out_value = r_out_value;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!i_func) begin
                        n_fill_word = i_seed;
                        n_cnt       = '0;
                        n_state     = S_FILL;
                    end else begin
                        n_warm  = 1'b0;
                        n_state = S_RDA;
                    end
                end
            end
            S_FILL: begin
                n_fill_word = rotl(r_fill_word, SEED_ROT) + t_word'(SEED_ADD);
                n_cnt       = t_idx'(r_cnt + 1'b1);
                if (r_cnt == LAST_IDX) begin
                    n_idx_a    = '0;
                    n_idx_b    = t_idx'(TAP_TWO_START);
                    n_idx_c    = t_idx'(TAP_THREE_START);
                    n_warm     = 1'b1;
                    n_warm_cnt = WARM_W'(WARMUP_DRAWS - 1);
                    n_state    = (WARMUP_DRAWS == 0) ? S_IDLE : S_RDA;
                end
            end
            S_RDA: n_state = S_RDB;
            S_RDB: begin
                n_word_a = r_rd_vld ? ram_rdata : '0;
                n_state  = S_RDC;
            end
            S_RDC: begin
                n_word_b = r_rd_vld ? ram_rdata : '0;
                n_state  = S_SUM;
            end
            S_SUM: begin
                if (proceed) begin
                    n_idx_a = step_down(r_idx_a);
                    n_idx_b = step_down(r_idx_b);
                    n_idx_c = step_down(r_idx_c);
                    if (r_warm) begin
                        if (r_warm_cnt == '0) begin
                            n_warm  = 1'b0;
                            n_state = S_IDLE;
                        end else begin
                            n_warm_cnt = r_warm_cnt - 1'b1;
                            n_state    = S_RDA;
                        end
                    end else begin
                        n_out_vld   = 1'b1;
                        n_out_value = sum;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx_a   <= '0;
            r_idx_b   <= t_idx'(TAP_TWO_START);
            r_idx_c   <= t_idx'(TAP_THREE_START);
            r_warm    <= 1'b0;
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx_a   <= n_idx_a;
            r_idx_b   <= n_idx_b;
            r_idx_c   <= n_idx_c;
            r_warm    <= n_warm;
            r_rd_vld  <= r_vld[ram_raddr];
            r_out_vld <= n_out_vld;
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_fill_word <= n_fill_word;
        r_warm_cnt  <= n_warm_cnt;
        r_word_a    <= n_word_a;
        r_word_b    <= n_word_b;
        r_out_value <= n_out_value;
    end

    // taps keep their fixed spacing around the ring
    a_tap_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (6'(r_idx_b) == 6'(r_idx_a) + 6'd10) || (6'(r_idx_a) == 6'(r_idx_b) + 6'd17))
        else $error("tap b out of step with write index");

    a_tap_three_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (6'(r_idx_c) == 6'(r_idx_a) + 6'd21) || (6'(r_idx_a) == 6'(r_idx_c) + 6'd6))
        else $error("tap c out of step with write index");

    a_fill_marks_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) && (r_cnt == LAST_IDX) |=> (&r_vld))
        else $error("ring not fully valid after reseed fill");

    a_stall_holds_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) && !r_warm && r_out_vld && !i_ready
        |=> (r_state == S_SUM) && $stable(r_idx_a))
        else $error("draw finished while output beat still pending");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_FILL) || (r_state == S_SUM))
        else $error("ring written outside fill or sum");

endmodule

// File: hw/rtl/rrb3_ram.sv
// generic single-write, single-read ram with registered read data
// one write port and one read port, both on i_clk
// no dependencies
module rrb3_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 27
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
